// File: rtl/vde_pkg.sv
// shared types and constants of the vector distance engine
// no dependencies
package vde_pkg;

    localparam int ELEM_W  = 16;
    localparam int SQ_W    = 33;
    localparam int PROD_W  = 32;
    localparam int DIFF_W  = 43;
    localparam int DOT_W   = 42;
    localparam int NORM_W  = 41;
    localparam int DIST_W  = 42;
    localparam int MET_W   = 2;
    localparam int MUL_W   = 42;
    localparam int CW      = 118;

    localparam logic [MET_W-1:0] MET_L2  = 2'd0;
    localparam logic [MET_W-1:0] MET_IP  = 2'd1;
    localparam logic [MET_W-1:0] MET_COS = 2'd2;

    localparam logic [DIST_W-1:0] Q16_ONE = 42'd65536;

    typedef struct packed {
        logic [MET_W-1:0]        metric;
        logic [DIFF_W-1:0]       diff;
        logic signed [DOT_W-1:0] dot;
        logic [NORM_W-1:0]       norm_a;
        logic [NORM_W-1:0]       norm_b;
    } t_job;

endpackage

// File: rtl/vde_front.sv
// front end: element products, saturating running sums, metric register
// uses vde_pkg; hands one job per vector to the queue
module vde_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [15:0]            i_elem_a,
    input  logic signed [15:0]            i_elem_b,
    input  logic                          i_last_element,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_data,
    output logic                          o_push,
    output vde_pkg::t_job                 o_job,
    input  logic                          i_full
);
    import vde_pkg::*;

    logic                     r_s1_valid;
    logic                     r_s1_last;
    logic [SQ_W-1:0]          r_s1_sqd, r_s1_sqa, r_s1_sqb;
    logic signed [PROD_W-1:0] r_s1_prod;
    logic [DIFF_W-1:0]        r_diff;
    logic signed [DOT_W-1:0]  r_dot;
    logic [NORM_W-1:0]        r_na, r_nb;
    logic [MET_W-1:0]         r_metric;

    logic signed [ELEM_W:0]   w_d;
    logic [ELEM_W:0]          w_ad, w_aa, w_ab;
    logic [2*ELEM_W+1:0]      w_sqd, w_sqa, w_sqb;
    logic signed [PROD_W-1:0] w_prod;
    logic [DIFF_W:0]          w_dsum;
    logic [NORM_W:0]          w_asum, w_bsum;
    logic signed [DOT_W:0]    w_dotsum;
    logic [DIFF_W-1:0]        n_diff;
    logic [NORM_W-1:0]        n_na, n_nb;
    logic signed [DOT_W-1:0]  n_dot;
    logic                     w_take;

    assign w_d   = (ELEM_W+1)'(i_elem_a) - (ELEM_W+1)'(i_elem_b);
    assign w_ad  = w_d[ELEM_W] ? (ELEM_W+1)'(-w_d) : (ELEM_W+1)'(w_d);
    assign w_aa  = i_elem_a[ELEM_W-1] ? (ELEM_W+1)'(-(ELEM_W+1)'(i_elem_a))
                                      : (ELEM_W+1)'(i_elem_a);
    assign w_ab  = i_elem_b[ELEM_W-1] ? (ELEM_W+1)'(-(ELEM_W+1)'(i_elem_b))
                                      : (ELEM_W+1)'(i_elem_b);
    assign w_sqd = {{(ELEM_W+1){1'b0}}, w_ad} * {{(ELEM_W+1){1'b0}}, w_ad};
    assign w_sqa = {{(ELEM_W+1){1'b0}}, w_aa} * {{(ELEM_W+1){1'b0}}, w_aa};
    assign w_sqb = {{(ELEM_W+1){1'b0}}, w_ab} * {{(ELEM_W+1){1'b0}}, w_ab};
    assign w_prod = PROD_W'(i_elem_a) * PROD_W'(i_elem_b);

    // the stage holds while a finished vector cannot enter the queue
    assign o_ready = !(r_s1_valid && r_s1_last && i_full);
    assign w_take  = r_s1_valid && o_ready;

    // sums never exceed their limit, so a carry out means saturate
    assign w_dsum   = {1'b0, r_diff} + (DIFF_W+1)'(r_s1_sqd);
    assign w_asum   = {1'b0, r_na} + (NORM_W+1)'(r_s1_sqa);
    assign w_bsum   = {1'b0, r_nb} + (NORM_W+1)'(r_s1_sqb);
    assign w_dotsum = (DOT_W+1)'(r_dot) + (DOT_W+1)'(r_s1_prod);
    assign n_diff   = w_dsum[DIFF_W] ? '1 : w_dsum[DIFF_W-1:0];
    assign n_na     = w_asum[NORM_W] ? '1 : w_asum[NORM_W-1:0];
    assign n_nb     = w_bsum[NORM_W] ? '1 : w_bsum[NORM_W-1:0];
    always_comb begin
        if (w_dotsum[DOT_W] != w_dotsum[DOT_W-1]) begin
            n_dot = w_dotsum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}}
                                    : {1'b0, {(DOT_W-1){1'b1}}};
        end else begin
            n_dot = w_dotsum[DOT_W-1:0];
        end
    end

    assign o_push       = w_take && r_s1_last;
    assign o_job.metric = r_metric;
    assign o_job.diff   = n_diff;
    assign o_job.dot    = n_dot;
    assign o_job.norm_a = n_na;
    assign o_job.norm_b = n_nb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_metric   <= MET_L2;
            r_diff     <= '0;
            r_dot      <= '0;
            r_na       <= '0;
            r_nb       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_metric <= i_cfg_data;
            end
            if (o_ready) begin
                r_s1_valid <= i_valid;
                r_s1_last  <= i_last_element;
                r_s1_sqd   <= w_sqd[SQ_W-1:0];
                r_s1_sqa   <= w_sqa[SQ_W-1:0];
                r_s1_sqb   <= w_sqb[SQ_W-1:0];
                r_s1_prod  <= w_prod;
            end
            if (w_take) begin
                if (r_s1_last) begin
                    r_diff <= '0;
                    r_dot  <= '0;
                    r_na   <= '0;
                    r_nb   <= '0;
                end else begin
                    r_diff <= n_diff;
                    r_dot  <= n_dot;
                    r_na   <= n_na;
                    r_nb   <= n_nb;
                end
            end
        end
    end

endmodule

// File: rtl/vde_queue.sv
// two-entry job queue between front and back
// uses vde_pkg
module vde_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vde_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output vde_pkg::t_job o_job,
    output logic          o_empty
);
    import vde_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// File: rtl/vde_back.sv
// back end: square root, serial multiplier and cosine search sequencer
// uses vde_pkg; holds the result beat in an output register
module vde_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  vde_pkg::t_job        i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [41:0]   o_distance,
    output logic                 o_zero_vector
);
    import vde_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQRT, ST_MUL, ST_COS_A, ST_COS_B, ST_DONE
    } t_state;

    t_state                r_state;
    logic [5:0]            r_cnt;
    logic [DIFF_W-1:0]     r_x, r_res, r_bit;
    logic [2*MUL_W-1:0]    r_ma, r_macc;
    logic [MUL_W-1:0]      r_mb, r_mag;
    logic                  r_sel, r_neg, r_cap;
    logic [CW-1:0]         r_p2j, r_dd, r_s, r_tsh, r_cand;
    logic [16:0]           r_k;
    logic [DIST_W-1:0]     r_dist;
    logic                  r_zero;

    logic [DIFF_W:0]       w_rb;
    logic                  w_ge;
    logic [DIFF_W-1:0]     n_res;
    logic [2*MUL_W-1:0]    n_macc;
    logic                  w_acc;
    logic [16:0]           n_k;
    logic [MUL_W-1:0]      w_mag;
    logic signed [DOT_W:0] w_ndot;

    assign w_rb  = {1'b0, r_res} + {1'b0, r_bit};
    assign w_ge  = ({1'b0, r_x} >= w_rb);
    assign n_res = w_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
    assign n_macc = r_macc + (r_mb[0] ? r_ma : '0);
    assign w_acc = !r_cap && (r_cand <= r_dd);
    assign n_k   = {r_k[15:0], w_acc};
    assign w_mag = i_job.dot[DOT_W-1] ? MUL_W'(-i_job.dot) : MUL_W'(i_job.dot);
    assign w_ndot = -(DOT_W+1)'(i_job.dot);

    assign o_pop         = (r_state == ST_IDLE) && !i_empty;
    assign o_valid       = (r_state == ST_DONE);
    assign o_distance    = r_dist;
    assign o_zero_vector = r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_neg  <= i_job.dot[DOT_W-1];
                        r_mag  <= w_mag;
                        if (i_job.metric == MET_IP) begin
                            r_zero <= 1'b0;
                            // clamp negated dot to plus or minus 2^40
                            if (w_ndot > (DOT_W+1)'(44'sd1099511627776)) begin
                                r_dist <= DIST_W'(44'sd1099511627776);
                            end else if (w_ndot < -(DOT_W+1)'(44'sd1099511627776)) begin
                                r_dist <= DIST_W'(-44'sd1099511627776);
                            end else begin
                                r_dist <= w_ndot[DIST_W-1:0];
                            end
                            r_state <= ST_DONE;
                        end else if (i_job.metric == MET_COS) begin
                            if (i_job.norm_a == '0 || i_job.norm_b == '0) begin
                                r_dist  <= Q16_ONE;
                                r_zero  <= 1'b1;
                                r_state <= ST_DONE;
                            end else begin
                                r_zero  <= 1'b0;
                                r_ma    <= (2*MUL_W)'(i_job.norm_a);
                                r_mb    <= MUL_W'(i_job.norm_b);
                                r_macc  <= '0;
                                r_cnt   <= 6'(MUL_W);
                                r_sel   <= 1'b0;
                                r_state <= ST_MUL;
                            end
                        end else begin
                            r_zero  <= 1'b0;
                            r_x     <= i_job.diff;
                            r_res   <= '0;
                            r_bit   <= DIFF_W'(1) << (DIFF_W - 1);
                            r_cnt   <= 6'((DIFF_W + 1) / 2);
                            r_state <= ST_SQRT;
                        end
                    end
                end
                ST_SQRT: begin
                    if (w_ge) begin
                        r_x <= r_x - w_rb[DIFF_W-1:0];
                    end
                    r_res <= n_res;
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_dist  <= DIST_W'(n_res);
                        r_state <= ST_DONE;
                    end
                end
                ST_MUL: begin
                    if (r_cnt == 6'd1 && !r_sel) begin
                        // norm product, pre-shifted for the top search bit
                        r_p2j  <= CW'(n_macc) << 32;
                        r_ma   <= (2*MUL_W)'(r_mag);
                        r_mb   <= r_mag;
                        r_macc <= '0;
                        r_cnt  <= 6'(MUL_W);
                        r_sel  <= 1'b1;
                    end else begin
                        r_macc <= n_macc;
                        r_ma   <= r_ma << 1;
                        r_mb   <= r_mb >> 1;
                        if (r_cnt == 6'd1) begin
                            r_dd    <= CW'(n_macc) << 32;
                            r_s     <= '0;
                            r_tsh   <= '0;
                            r_k     <= '0;
                            r_cap   <= 1'b0;
                            r_cnt   <= 6'd17;
                            r_state <= ST_COS_A;
                        end else begin
                            r_cnt <= r_cnt - 6'd1;
                        end
                    end
                end
                ST_COS_A: begin
                    r_cand  <= r_s + r_tsh + r_p2j;
                    r_state <= ST_COS_B;
                end
                ST_COS_B: begin
                    if (w_acc) begin
                        r_s <= r_cand;
                    end
                    if (r_cnt == 6'd17) begin
                        r_cap <= w_acc;
                    end
                    r_tsh <= (r_tsh >> 1) + (w_acc ? r_p2j : '0);
                    r_p2j <= r_p2j >> 2;
                    r_k   <= n_k;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_dist  <= r_neg ? (Q16_ONE + DIST_W'(n_k))
                                         : (Q16_ONE - DIST_W'(n_k));
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_COS_A;
                    end
                end
                ST_DONE: begin
                    if (i_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/vector_distance_engine_unit.sv
// top level of the streaming vector distance engine
// depends on vde_pkg, vde_front, vde_queue and vde_back
//
// one element pair enters per beat (i_valid/o_ready) and is folded into four
// saturating sums via the s1 register and the sum registers; the front takes
// a pair every cycle unless a finished vector waits on a full queue. the beat
// flagged i_last_element closes the vector; its sums go to a two-entry queue.
// the back takes jobs one at a time: inner product goes straight to the output
// register, L2 runs a square root (one root bit per cycle), cosine runs two
// shift-add multiplies, then 17 search bits through ST_COS_A and ST_COS_B.
// the result beat waits in the output register (o_valid/i_ready). the back
// sets sustained rate; short vectors stall the front once the queue is full
module vector_distance_engine_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // element pair channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_elem_a,
    input  logic signed [15:0] i_elem_b,
    input  logic               i_last_element,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [41:0] o_distance,
    output logic               o_zero_vector,
    // metric register: 0 L2, 1 negated inner product, 2 cosine
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data
);
    import vde_pkg::*;

    t_job w_push_job, w_pop_job;
    logic w_push, w_full, w_pop, w_empty;

    // accumulation side
    vde_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_elem_a       (i_elem_a),
        .i_elem_b       (i_elem_b),
        .i_last_element (i_last_element),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_push         (w_push),
        .o_job          (w_push_job),
        .i_full         (w_full)
    );

    // finished vectors waiting for the back
    vde_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty)
    );

    // root, cosine search and output register
    vde_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_job         (w_pop_job),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_distance    (o_distance),
        .o_zero_vector (o_zero_vector)
    );

endmodule

// File: verif/testbench.sv
// self-checking testbench for vector_distance_engine_unit
// streams element pairs, predicts each vector distance and checks result beats
// depends on vde_pkg and the rtl of the unit
`timescale 1ns / 1ps

module testbench;
    import vde_pkg::*;

    localparam int IDLE_TAIL = 400;
    localparam int WD_LIMIT  = 20000;

    typedef struct {
        logic signed [DIST_W-1:0] distance;
        logic                     zero_vector;
    } t_dist;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [15:0] i_elem_a;
    logic signed [15:0] i_elem_b;
    logic               i_last_element;
    logic               o_valid;
    logic               i_ready;
    logic signed [41:0] o_distance;
    logic               o_zero_vector;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_data;

    // predictor state
    logic [1:0]                  cur_metric;
    logic [DIFF_W-1:0]           sq_diff_acc;
    logic signed [DOT_W-1:0]     dot_acc;
    logic [NORM_W-1:0]           norm_a_acc;
    logic [NORM_W-1:0]           norm_b_acc;

    t_dist expected_dist_q[$];
    int    n_fail;
    int    idle_cycles;
    bit    timed_out;
    bit    stim_done;

    vector_distance_engine_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_elem_a       (i_elem_a),
        .i_elem_b       (i_elem_b),
        .i_last_element (i_last_element),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_distance     (o_distance),
        .o_zero_vector  (o_zero_vector),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // floor square root, bit by bit
    function automatic logic [DIFF_W-1:0] int_root(input logic [DIFF_W-1:0] x);
        logic [DIFF_W-1:0] r;
        r = '0;
        for (int b = 21; b >= 0; b--) begin
            logic [DIFF_W-1:0] t;
            t = r | (43'd1 << b);
            if (88'(t) * 88'(t) <= 88'(x)) r = t;
        end
        return r;
    endfunction

    // cosine distance in q2.16: largest k with k^2*na*nb <= dot^2*2^32
    function automatic logic [DIST_W-1:0] cosine_dist();
        logic [255:0] prod_n, dsq, lhs;
        logic [63:0]  mag;
        logic [16:0]  lo, hi, mid;
        mag = dot_acc < 0 ? 64'(-64'(dot_acc)) : 64'(dot_acc);
        prod_n = 256'(norm_a_acc) * 256'(norm_b_acc);
        dsq = (256'(mag) * 256'(mag)) << 32;
        lo = 0;
        hi = 17'd65536;
        while (lo < hi) begin
            mid = 17'((18'(lo) + 18'(hi) + 1) >> 1);
            lhs = prod_n * (256'(mid) * 256'(mid));
            if (lhs <= dsq) lo = mid;
            else hi = mid - 1;
        end
        return dot_acc < 0 ? 42'(65536 + lo) : 42'(65536 - lo);
    endfunction

    // fold one pair into the sums; on the last pair queue the distance
    task automatic fold_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                             input logic last);
        logic signed [17:0] d;
        logic [63:0]        w;
        logic signed [63:0] sd;
        t_dist              r;
        d  = 18'(a) - 18'(b);
        w  = 64'(sq_diff_acc) + 64'(d * d);
        sq_diff_acc = w > ((64'd1 << 43) - 64'd1) ? '1 : w[DIFF_W-1:0];
        w  = 64'(norm_a_acc) + 64'(32'(a) * 32'(a));
        norm_a_acc = w > ((64'd1 << 41) - 64'd1) ? '1 : w[NORM_W-1:0];
        w  = 64'(norm_b_acc) + 64'(32'(b) * 32'(b));
        norm_b_acc = w > ((64'd1 << 41) - 64'd1) ? '1 : w[NORM_W-1:0];
        sd = 64'(dot_acc) + 64'(32'(a) * 32'(b));
        if (sd > 64'sd2199023255551) sd = 64'sd2199023255551;
        if (sd < -64'sd2199023255552) sd = -64'sd2199023255552;
        dot_acc = sd[DOT_W-1:0];
        if (!last) return;
        r.zero_vector = 1'b0;
        if (cur_metric == MET_IP) begin
            sd = -64'(dot_acc);
            if (sd > 64'sd1099511627776) sd = 64'sd1099511627776;
            if (sd < -64'sd1099511627776) sd = -64'sd1099511627776;
            r.distance = sd[DIST_W-1:0];
        end else if (cur_metric == MET_COS) begin
            if (norm_a_acc == 0 || norm_b_acc == 0) begin
                r.distance = Q16_ONE;
                r.zero_vector = 1'b1;
            end else begin
                r.distance = cosine_dist();
            end
        end else begin
            r.distance = 42'(int_root(sq_diff_acc));
        end
        expected_dist_q.push_back(r);
        sq_diff_acc = '0;
        dot_acc = '0;
        norm_a_acc = '0;
        norm_b_acc = '0;
    endtask

    // one beat on the pair channel, sometimes with a random gap before it
    task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                             input logic last, input bit gaps = 1);
        if (gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_elem_a       <= a;
        i_elem_b       <= b;
        i_last_element <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        fold_pair(a, b, last);
    endtask

    // park the channel and wait until every distance has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_dist_q.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    task automatic set_metric(input logic [1:0] m);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_metric = m;
    endtask

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    // directed: extremes, zero vectors, single pairs, opposite vectors
    task automatic test_directed(input logic [1:0] m);
        set_metric(m);
        send_pair(16'sh8000, 16'sh7fff, 1'b1);
        send_pair(16'sh7fff, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(16'sh0000, 16'sh0005, 1'b1);
        send_pair(16'sh0000, 16'sh0000, 1'b1);
        send_pair(16'sh0003, 16'sh0004, 1'b0);
        send_pair(16'sh0004, -16'sh0003, 1'b1);
        send_pair(16'shffff, 16'sh0001, 1'b1);
    endtask

    // random vectors, mostly short, under random metric changes
    task automatic test_random(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) set_metric(2'($urandom_range(0, 3)));
            len = $urandom_range(0, 7) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send_pair(rand_elem(), rand_elem(), i == len - 1);
            sent += len;
            if ($urandom_range(0, 30) == 0) drain();
        end
    endtask

    // result checker and receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_dist_q.size() == 0) begin
                    $error("distance beat with none expected");
                    n_fail++;
                end else begin
                    t_dist e;
                    e = expected_dist_q.pop_front();
                    if (o_distance !== e.distance) begin
                        $error("distance: expected %0d actual %0d", e.distance, o_distance);
                        n_fail++;
                    end
                    if (o_zero_vector !== e.zero_vector) begin
                        $error("zero_vector: expected %0b actual %0b",
                               e.zero_vector, o_zero_vector);
                        n_fail++;
                    end
                end
            end
            // ready drawn at random, high far more often than low
            i_ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 2) == 0);
        end
    end

    // watchdog on cycles with no beat accepted on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        n_fail = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_elem_a = '0;
        i_elem_b = '0;
        i_last_element = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        cur_metric = MET_L2;
        sq_diff_acc = '0;
        dot_acc = '0;
        norm_a_acc = '0;
        norm_b_acc = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed(MET_L2);
        test_directed(MET_IP);
        test_directed(MET_COS);
        test_directed(2'd3);
        test_random(660);
        drain();
        stim_done = 1'b1;

        if (n_fail == 0 && expected_dist_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            if (expected_dist_q.size() != 0)
                $error("distance beats missing: %0d", expected_dist_q.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
